>>> design/srp_pkg.sv
// shared types, constants and scaling functions for the servo ramp profiler
package srp_pkg;

  localparam int DEG_W  = 7;
  localparam int PCT_W  = 7;
  localparam int MPD_W  = 10;
  localparam int LEN_W  = 17;
  localparam int TIME_W = 32;
  localparam int NUM_W  = 24;
  localparam int ALU_W  = 25;
  localparam int CNT_W  = 5;

  localparam logic [DEG_W-1:0] MAX_DEG     = 7'd90;
  localparam logic [DEG_W-1:0] FOLLOW_HYST = 7'd2;
  localparam logic [1:0]       MODE_AUTO   = 2'd1;
  localparam logic [1:0]       MODE_UNCONN = 2'd2;
  localparam logic [MPD_W-1:0] MPD_RESET   = 10'd10;

  // reciprocal constants, 16 fractional bits
  localparam logic [16:0] PCT2DEG_K = 17'd58983;
  localparam logic [16:0] DEG2PCT_K = 17'd72818;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [1:0]        mode;
    logic              pot_changed;
    logic [PCT_W-1:0]  pot_percent;
    logic              remote_valid;
    logic [DEG_W-1:0]  remote_angle;
  } srp_in_t;

  typedef struct packed {
    logic [DEG_W-1:0] servo_angle;
    logic [PCT_W-1:0] display_percent;
  } srp_out_t;

  typedef struct packed {
    logic             idle;
    logic             done;
    logic [DEG_W-1:0] angle;
  } srp_stat_t;

  function automatic logic [DEG_W-1:0] clamp_deg(input logic [DEG_W-1:0] v);
    return (v > MAX_DEG) ? MAX_DEG : v;
  endfunction

  // floor(p*90/100)
  function automatic logic [DEG_W-1:0] pct_to_deg(input logic [PCT_W-1:0] p);
    logic [23:0] prod;
    prod = {17'd0, p} * {7'd0, PCT2DEG_K};
    return clamp_deg(prod[22:16]);
  endfunction

  // floor(x*100/90) for x up to 90
  function automatic logic [PCT_W-1:0] deg_to_pct(input logic [DEG_W-1:0] x);
    logic [23:0] prod;
    prod = {17'd0, x} * {7'd0, DEG2PCT_K};
    return prod[22:16];
  endfunction

endpackage

>>> design/servo_ramp_profiler_unit.sv
// top level of the servo ramp profiler: handshakes, config register, result register
// One request is one tick. When the tick takes a new target, a 7-step shift-add product
// of travel and the ramp rate in ms per degree gives the ramp length. When the angle is
// interpolated along a ramp, a 7-step product dt*span, a 24-step restoring divide and
// one step to form the angle follow. The multiply and divide steps share one adder.
// in_stall stays high while a tick is in work. The result waits in an output register,
// and the next request is taken once that result has moved into it. The ramp rate resets
// to 10 and is written through cfg_wr_en / cfg_wr_data; the user must write it only while
// the block is idle, as the block itself does not enforce this.
module servo_ramp_profiler_unit import srp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  srp_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output srp_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [MPD_W-1:0] cfg_wr_data
);

  logic [MPD_W-1:0] mpd_r;
  logic             out_valid_r;
  srp_out_t         out_data_r;
  logic             out_free;
  logic             start;
  srp_stat_t        stat;

  assign out_free = !out_valid_r || !out_stall;
  assign start    = in_valid && stat.idle;
  assign in_stall = !stat.idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpd_r <= MPD_RESET;
    end else if (cfg_wr_en) begin
      mpd_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_data_r.servo_angle     <= stat.angle;
      out_data_r.display_percent <= deg_to_pct(stat.angle);
    end
  end

  srp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .item     (in_data),
    .out_free (out_free),
    .mpd      (mpd_r),
    .stat     (stat)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/srp_alu.sv
// shared adder/subtractor used by the multiply and divide iterations
module srp_alu import srp_pkg::*; (
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  input  logic             sub,
  output logic [ALU_W-1:0] sum,
  output logic             carry
);

  logic [ALU_W-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_op} + {{ALU_W{1'b0}}, sub};

endmodule

>>> design/srp_core.sv
// target selection, ramp state and sequencer around the shared alu
module srp_core import srp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  srp_in_t          item,
  input  logic             out_free,
  input  logic [MPD_W-1:0] mpd,
  output srp_stat_t        stat
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LEN  = 7'b0000010,
    S_CHK  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t            state_r;
  logic [DEG_W-1:0]  target_r;
  logic [DEG_W-1:0]  last_r;
  logic [DEG_W-1:0]  start_deg_r;
  logic [DEG_W-1:0]  cmd_r;
  logic [TIME_W-1:0] start_time_r;
  logic [LEN_W-1:0]  len_r;
  logic              pend_r;
  logic [DEG_W-1:0]  latch_r;
  logic [TIME_W-1:0] now_r;
  logic [NUM_W-1:0]  acc_r;
  logic [NUM_W-1:0]  mcand_r;
  logic [DEG_W-1:0]  mplier_r;
  logic [LEN_W:0]    rem_r;
  logic [NUM_W-1:0]  qr_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [DEG_W-1:0]  remote_c;
  logic [DEG_W-1:0]  latch_c;
  logic              pend_c;
  logic              take_c;
  logic              set_last_c;
  logic              clr_pend_c;
  logic [DEG_W-1:0]  new_tgt_c;
  logic [DEG_W-1:0]  follow_diff_c;
  logic [DEG_W-1:0]  span_new_c;
  logic [DEG_W-1:0]  span_c;
  logic [TIME_W-1:0] dt_c;
  logic              in_ramp_c;
  logic [NUM_W-1:0]  acc_step_c;
  logic [LEN_W:0]    trial_c;
  logic [ALU_W-1:0]  alu_a;
  logic [ALU_W-1:0]  alu_b;
  logic              alu_sub;
  logic [ALU_W-1:0]  alu_sum;
  logic              alu_carry;
  logic [7:0]        q8_c;
  logic [7:0]        up_c;
  logic [8:0]        down_c;
  logic [DEG_W-1:0]  ramp_angle_c;

  // target selection for the request being accepted
  always_comb begin
    remote_c   = clamp_deg(item.remote_angle);
    latch_c    = item.remote_valid ? remote_c : latch_r;
    pend_c     = item.remote_valid | pend_r;
    take_c     = 1'b0;
    set_last_c = 1'b0;
    clr_pend_c = 1'b0;
    new_tgt_c  = target_r;
    follow_diff_c = (remote_c >= last_r) ? (remote_c - last_r) : (last_r - remote_c);
    if (item.mode != MODE_AUTO) begin
      if (item.pot_changed) begin
        take_c     = 1'b1;
        set_last_c = 1'b1;
        new_tgt_c  = pct_to_deg(item.pot_percent);
      end else if (pend_c && (item.mode != MODE_UNCONN)) begin
        take_c     = 1'b1;
        clr_pend_c = 1'b1;
        new_tgt_c  = latch_c;
      end
    end else if (follow_diff_c >= FOLLOW_HYST) begin
      take_c     = 1'b1;
      set_last_c = 1'b1;
      new_tgt_c  = remote_c;
    end
  end

  assign span_new_c = (new_tgt_c >= cmd_r) ? (new_tgt_c - cmd_r) : (cmd_r - new_tgt_c);
  assign span_c = (target_r >= start_deg_r) ? (target_r - start_deg_r)
                                            : (start_deg_r - target_r);

  assign dt_c = now_r - start_time_r;
  assign in_ramp_c = (dt_c[TIME_W-1:LEN_W] == '0) && (dt_c[LEN_W-1:0] <= len_r);

  assign trial_c = {rem_r[LEN_W-1:0], qr_r[NUM_W-1]};

  always_comb begin
    if (state_r == S_DIV) begin
      alu_a   = {{(ALU_W-LEN_W-1){1'b0}}, trial_c};
      alu_b   = {{(ALU_W-LEN_W){1'b0}}, len_r};
      alu_sub = 1'b1;
    end else begin
      alu_a   = {1'b0, acc_r};
      alu_b   = {1'b0, mcand_r};
      alu_sub = 1'b0;
    end
  end

  srp_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  assign acc_step_c = mplier_r[0] ? alu_sum[NUM_W-1:0] : acc_r;

  // quotient never exceeds the span, so eight bits hold it
  always_comb begin
    q8_c   = qr_r[7:0];
    up_c   = {1'b0, start_deg_r} + q8_c;
    down_c = {1'b0, q8_c} + {8'd0, (rem_r != '0)};
    if (target_r >= start_deg_r) begin
      ramp_angle_c = (up_c > {1'b0, MAX_DEG}) ? MAX_DEG : up_c[DEG_W-1:0];
    end else if (down_c >= {2'b00, start_deg_r}) begin
      ramp_angle_c = '0;
    end else begin
      ramp_angle_c = clamp_deg(start_deg_r - down_c[DEG_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      target_r     <= '0;
      last_r       <= '0;
      start_deg_r  <= '0;
      cmd_r        <= '0;
      start_time_r <= '0;
      len_r        <= '0;
      pend_r       <= 1'b0;
      latch_r      <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            latch_r <= latch_c;
            pend_r  <= clr_pend_c ? 1'b0 : pend_c;
            now_r   <= item.now_ms;
            if (take_c) begin
              target_r     <= new_tgt_c;
              start_deg_r  <= cmd_r;
              start_time_r <= item.now_ms;
              acc_r        <= '0;
              mcand_r      <= {{(NUM_W-MPD_W){1'b0}}, mpd};
              mplier_r     <= span_new_c;
              cnt_r        <= '0;
              state_r      <= S_LEN;
            end else begin
              state_r <= S_CHK;
            end
            if (set_last_c) begin
              last_r <= new_tgt_c;
            end
          end
        end
        S_LEN: begin
          acc_r    <= acc_step_c;
          mcand_r  <= {mcand_r[NUM_W-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[DEG_W-1:1]};
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DEG_W-1)) begin
            len_r   <= (acc_step_c == '0) ? LEN_W'(1) : acc_step_c[LEN_W-1:0];
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (in_ramp_c && (cmd_r != target_r)) begin
            acc_r    <= '0;
            mcand_r  <= {{(NUM_W-LEN_W){1'b0}}, dt_c[LEN_W-1:0]};
            mplier_r <= span_c;
            cnt_r    <= '0;
            state_r  <= S_MUL;
          end else begin
            cmd_r   <= target_r;
            state_r <= S_DONE;
          end
        end
        S_MUL: begin
          acc_r    <= acc_step_c;
          mcand_r  <= {mcand_r[NUM_W-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[DEG_W-1:1]};
          if (cnt_r == CNT_W'(DEG_W-1)) begin
            qr_r    <= acc_step_c;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DIV: begin
          rem_r <= alu_carry ? alu_sum[LEN_W:0] : trial_c;
          qr_r  <= {qr_r[NUM_W-2:0], alu_carry};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(NUM_W-1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          cmd_r   <= ramp_angle_c;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.idle  = (state_r == S_IDLE);
  assign stat.done  = (state_r == S_DONE) && out_free;
  assign stat.angle = cmd_r;

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after result");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r <= MAX_DEG)
    else $error("commanded angle out of range");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (len_r != '0))
    else $error("divide started with zero ramp length");

  a_mul_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (cmd_r != target_r))
    else $error("ramp interpolation with angle already at target");

endmodule
